/* rtl/slsp_pkg.sv */
// Shared types and constants for the sorted linked stack pool.
// Used by slsp_ctrl and sorted_linked_stack_pool; no dependencies.
package slsp_pkg;

	// Default pool size and data word width
	localparam int unsigned DefPoolNodes = 8;
	localparam int unsigned DATA_W       = 32;

	// Operation codes carried in the input transaction
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_INSERT = 2'd2
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_DROP  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Controller sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_UPD,
		ST_POP_TOP_RD,
		ST_POP_TOP_VAL,
		ST_INS_START,
		ST_INS_CMP,
		ST_ALLOC,
		ST_ALLOC_TAKE,
		ST_NEW_WR,
		ST_PREV_WR,
		ST_FINISH
	} state_t;

	// One result transaction
	typedef struct packed {
		status_t            status;
		logic               is_full;
		logic               is_empty;
		logic [3:0]         negative_count;
		logic [3:0]         depth;
		logic [DATA_W-1:0]  top_value;
	} result_t;

endpackage

/* rtl/slsp_node_ram.sv */
// Single-port node memory of the pool: one {next, value} word per node.
// Read data is registered. Depends on nothing.
module slsp_node_ram #(
	parameter int unsigned POOL_NODES = 8,
	parameter int unsigned WORD_W     = 36
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          we,
	input  logic [$clog2(POOL_NODES)-1:0] addr,
	input  logic [WORD_W-1:0]             wdata,
	output logic [WORD_W-1:0]             rdata
);

	logic [WORD_W-1:0] mem [POOL_NODES];

	// Write or read one entry per cycle while en is high
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/slsp_ctrl.sv */
// Sequencer for push, pop and sorted insert over the linked node pool.
// Depends on slsp_pkg; drives the port of slsp_node_ram.
module slsp_ctrl #(
	parameter int unsigned POOL_NODES = slsp_pkg::DefPoolNodes,
	localparam int unsigned AW = $clog2(POOL_NODES),
	localparam int unsigned PW = AW + 1,
	localparam int unsigned CW = $clog2(POOL_NODES + 1),
	localparam int unsigned WW = slsp_pkg::DATA_W + PW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input transaction
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  in_opcode,
	input  logic [slsp_pkg::DATA_W-1:0] in_value,
	// result hand-off
	input  logic                        res_free,
	output logic                        res_valid,
	output slsp_pkg::result_t           res,
	// node memory port
	output logic                        mem_en,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_addr,
	output logic [WW-1:0]               mem_wdata,
	input  logic [WW-1:0]               mem_rdata
);

	// Pointer MSB set means no node
	localparam logic [PW-1:0] NIL = {PW{1'b1}};

	slsp_pkg::state_t  state_q, state_d;
	logic [1:0]        op_q;
	logic signed [slsp_pkg::DATA_W-1:0] val_q, top_val_q, prev_val_q;
	slsp_pkg::status_t status_q;
	logic [PW-1:0]     top_q, rec_head_q, cur_q, prev_q;
	logic [AW-1:0]     alloc_q;
	logic [CW-1:0]     fresh_q, count_q, neg_q;

	logic                               full_w, top_nil_w, top_gt_w, rd_gt_w, rd_next_nil_w;
	logic signed [slsp_pkg::DATA_W-1:0] in_val_w, rd_val_w;
	logic [PW-1:0]                      rd_next_w;
	logic [CW+3:0]                      depth_ext_w, neg_ext_w;

	assign in_val_w      = in_value;
	assign rd_val_w      = mem_rdata[slsp_pkg::DATA_W-1:0];
	assign rd_next_w     = mem_rdata[WW-1:slsp_pkg::DATA_W];
	assign rd_next_nil_w = rd_next_w[AW];
	assign rd_gt_w       = rd_val_w > val_q;
	assign full_w        = (count_q == CW'(POOL_NODES));
	assign top_nil_w     = top_q[AW];
	assign top_gt_w      = top_val_q > in_val_w;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slsp_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (in_opcode)
						slsp_pkg::OP_PUSH:
							state_d = full_w ? slsp_pkg::ST_FINISH : slsp_pkg::ST_ALLOC;
						slsp_pkg::OP_POP:
							state_d = top_nil_w ? slsp_pkg::ST_FINISH : slsp_pkg::ST_POP_RD;
						slsp_pkg::OP_INSERT: begin
							if (!full_w) begin
								state_d = slsp_pkg::ST_INS_START;
							end else begin
								state_d = top_gt_w ? slsp_pkg::ST_POP_RD : slsp_pkg::ST_FINISH;
							end
						end
						default: state_d = slsp_pkg::ST_FINISH;
					endcase
				end
			end
			slsp_pkg::ST_POP_RD: state_d = slsp_pkg::ST_POP_UPD;
			slsp_pkg::ST_POP_UPD: begin
				if (!rd_next_nil_w) begin
					state_d = slsp_pkg::ST_POP_TOP_RD;
				end else if (op_q == slsp_pkg::OP_INSERT) begin
					state_d = slsp_pkg::ST_INS_START;
				end else begin
					state_d = slsp_pkg::ST_FINISH;
				end
			end
			slsp_pkg::ST_POP_TOP_RD: state_d = slsp_pkg::ST_POP_TOP_VAL;
			slsp_pkg::ST_POP_TOP_VAL:
				state_d = (op_q == slsp_pkg::OP_INSERT) ? slsp_pkg::ST_INS_START
					: slsp_pkg::ST_FINISH;
			slsp_pkg::ST_INS_START:
				state_d = top_nil_w ? slsp_pkg::ST_ALLOC : slsp_pkg::ST_INS_CMP;
			slsp_pkg::ST_INS_CMP: begin
				if (!rd_gt_w || rd_next_nil_w) begin
					state_d = slsp_pkg::ST_ALLOC;
				end
			end
			slsp_pkg::ST_ALLOC:
				state_d = rec_head_q[AW] ? slsp_pkg::ST_NEW_WR : slsp_pkg::ST_ALLOC_TAKE;
			slsp_pkg::ST_ALLOC_TAKE: state_d = slsp_pkg::ST_NEW_WR;
			slsp_pkg::ST_NEW_WR:
				state_d = prev_q[AW] ? slsp_pkg::ST_FINISH : slsp_pkg::ST_PREV_WR;
			slsp_pkg::ST_PREV_WR: state_d = slsp_pkg::ST_FINISH;
			slsp_pkg::ST_FINISH: begin
				if (res_free) begin
					state_d = slsp_pkg::ST_IDLE;
				end
			end
			default: state_d = slsp_pkg::ST_IDLE;
		endcase
	end

	// Memory port and handshake outputs
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			slsp_pkg::ST_POP_RD, slsp_pkg::ST_POP_TOP_RD: begin
				mem_en   = 1'b1;
				mem_addr = top_q[AW-1:0];
			end
			slsp_pkg::ST_POP_UPD: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = top_q[AW-1:0];
				mem_wdata = {rec_head_q, top_val_q};
			end
			slsp_pkg::ST_INS_START: begin
				mem_en   = !top_nil_w;
				mem_addr = top_q[AW-1:0];
			end
			slsp_pkg::ST_INS_CMP: begin
				mem_en   = rd_gt_w && !rd_next_nil_w;
				mem_addr = rd_next_w[AW-1:0];
			end
			slsp_pkg::ST_ALLOC: begin
				mem_en   = !rec_head_q[AW];
				mem_addr = rec_head_q[AW-1:0];
			end
			slsp_pkg::ST_NEW_WR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = alloc_q;
				mem_wdata = {cur_q, val_q};
			end
			slsp_pkg::ST_PREV_WR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = prev_q[AW-1:0];
				mem_wdata = {1'b0, alloc_q, prev_val_q};
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == slsp_pkg::ST_IDLE);
	assign res_valid = (state_q == slsp_pkg::ST_FINISH);

	// Build the result from the current state
	assign depth_ext_w = {4'b0, count_q};
	assign neg_ext_w   = {4'b0, neg_q};
	always_comb begin
		res.top_value      = top_nil_w ? '0 : top_val_q;
		res.depth          = depth_ext_w[3:0];
		res.negative_count = neg_ext_w[3:0];
		res.is_empty       = top_nil_w;
		res.is_full        = full_w;
		res.status         = status_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slsp_pkg::ST_IDLE;
			top_q      <= NIL;
			rec_head_q <= NIL;
			fresh_q    <= '0;
			count_q    <= '0;
			neg_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				slsp_pkg::ST_POP_UPD: begin
					rec_head_q <= top_q;
					top_q      <= rd_next_w;
					count_q    <= count_q - 1'b1;
					neg_q      <= neg_q - CW'(top_val_q[slsp_pkg::DATA_W-1]);
				end
				slsp_pkg::ST_ALLOC: begin
					if (rec_head_q[AW]) begin
						fresh_q <= fresh_q + 1'b1;
					end
				end
				slsp_pkg::ST_ALLOC_TAKE: begin
					rec_head_q <= rd_next_w;
				end
				slsp_pkg::ST_NEW_WR: begin
					count_q <= count_q + 1'b1;
					neg_q   <= neg_q + CW'(val_q[slsp_pkg::DATA_W-1]);
					if (prev_q[AW]) begin
						top_q <= {1'b0, alloc_q};
					end
				end
				default: begin
					top_q <= top_q;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			slsp_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q   <= in_opcode;
					val_q  <= in_val_w;
					cur_q  <= top_q;
					prev_q <= NIL;
					if ((in_opcode == slsp_pkg::OP_PUSH || in_opcode == slsp_pkg::OP_INSERT)
						&& full_w) begin
						status_q <= slsp_pkg::STAT_DROP;
					end else if (in_opcode == slsp_pkg::OP_POP && top_nil_w) begin
						status_q <= slsp_pkg::STAT_EMPTY;
					end else begin
						status_q <= slsp_pkg::STAT_OK;
					end
				end
			end
			slsp_pkg::ST_POP_TOP_VAL: begin
				top_val_q <= rd_val_w;
			end
			slsp_pkg::ST_INS_START: begin
				cur_q  <= top_q;
				prev_q <= NIL;
			end
			slsp_pkg::ST_INS_CMP: begin
				if (rd_gt_w) begin
					prev_q     <= cur_q;
					prev_val_q <= rd_val_w;
					cur_q      <= rd_next_w;
				end
			end
			slsp_pkg::ST_ALLOC: begin
				if (rec_head_q[AW]) begin
					alloc_q <= fresh_q[AW-1:0];
				end
			end
			slsp_pkg::ST_ALLOC_TAKE: begin
				alloc_q <= rec_head_q[AW-1:0];
			end
			slsp_pkg::ST_NEW_WR: begin
				if (prev_q[AW]) begin
					top_val_q <= val_q;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

endmodule

/* rtl/sorted_linked_stack_pool.sv */
// Sorted linked stack pool: stack of signed words as a linked list in a node memory.
// Sorted insert walks the list, comparing one node at a time; an up-front drop or empty pop
// goes straight to the result without touching node memory.
// One transaction in flight; the next is accepted only after its result is registered.
// Reset (arst_n low) empties the stack; node memory is not cleared.
// Depends on slsp_pkg, slsp_ctrl and slsp_node_ram.
module sorted_linked_stack_pool #(
	parameter int unsigned POOL_NODES = slsp_pkg::DefPoolNodes
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // opcode[1:0], value[33:2], zero pad
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // top_value, depth, negative_count,
	                              // is_empty, is_full, status, zero pad
);

	localparam int unsigned AW = $clog2(POOL_NODES);
	localparam int unsigned WW = slsp_pkg::DATA_W + AW + 1;

	logic              mem_en, mem_we;
	logic [AW-1:0]     mem_addr;
	logic [WW-1:0]     mem_wdata, mem_rdata;
	logic              res_valid, res_free;
	slsp_pkg::result_t res, out_q;
	logic              out_valid_q;

	assign res_free = !out_valid_q || m_tready;

	slsp_ctrl #(
		.POOL_NODES(POOL_NODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tdata[1:0]),
		.in_value  (s_tdata[33:2]),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	slsp_node_ram #(
		.POOL_NODES(POOL_NODES),
		.WORD_W    (WW)
	) u_node_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_q};

endmodule
